// ----- rtl/rntd_pkg.sv -----
// rntd_pkg: letter codes, item struct and numeral lookup functions
// shared by the roman numeral token decoder; no dependencies
package rntd_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 24;
   localparam int ADD_WIDTH   = 11;   // largest single step adds 1000 + 1000
   localparam int NORMAL_MAX  = 3999;

   typedef enum logic [2:0] {
      LETTER_NONE = 3'd0,
      LETTER_I    = 3'd1,
      LETTER_V    = 3'd2,
      LETTER_X    = 3'd3,
      LETTER_L    = 3'd4,
      LETTER_C    = 3'd5,
      LETTER_D    = 3'd6,
      LETTER_M    = 3'd7
   } letter_type;

   typedef struct packed {
      letter_type letter;
      logic       last;
   } item_type;

   // either case maps to the same letter, everything else is a separator
   function automatic letter_type letter_code(input logic [CHAR_WIDTH-1:0] ch);
      letter_type code;
      case (ch)
         "I", "i": code = LETTER_I;
         "V", "v": code = LETTER_V;
         "X", "x": code = LETTER_X;
         "L", "l": code = LETTER_L;
         "C", "c": code = LETTER_C;
         "D", "d": code = LETTER_D;
         "M", "m": code = LETTER_M;
         default:  code = LETTER_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [ADD_WIDTH-1:0] letter_value(input letter_type l);
      logic [ADD_WIDTH-1:0] v;
      case (l)
         LETTER_I: v = ADD_WIDTH'(1);
         LETTER_V: v = ADD_WIDTH'(5);
         LETTER_X: v = ADD_WIDTH'(10);
         LETTER_L: v = ADD_WIDTH'(50);
         LETTER_C: v = ADD_WIDTH'(100);
         LETTER_D: v = ADD_WIDTH'(500);
         LETTER_M: v = ADD_WIDTH'(1000);
         default:  v = '0;
      endcase
      return v;
   endfunction

   // subtractive pair value, zero when the two letters form no pair
   function automatic logic [ADD_WIDTH-1:0] pair_value(input letter_type held,
                                                       input letter_type next);
      logic [ADD_WIDTH-1:0] v;
      v = '0;
      if (held == LETTER_C && next == LETTER_M) v = ADD_WIDTH'(900);
      if (held == LETTER_C && next == LETTER_D) v = ADD_WIDTH'(400);
      if (held == LETTER_X && next == LETTER_C) v = ADD_WIDTH'(90);
      if (held == LETTER_X && next == LETTER_L) v = ADD_WIDTH'(40);
      if (held == LETTER_I && next == LETTER_X) v = ADD_WIDTH'(9);
      if (held == LETTER_I && next == LETTER_V) v = ADD_WIDTH'(4);
      return v;
   endfunction

endpackage

// ----- rtl/rntd_char_stage.sv -----
// rntd_char_stage: input register, classifies each character into a letter code
// depends on rntd_pkg
module rntd_char_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rntd_pkg::CHAR_WIDTH-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          item_valid,
   output rntd_pkg::item_type            item,
   input  logic                          item_take
);
   import rntd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_tready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tvalid && req_tready) begin
         valid_in       = 1'b1;
         item_in.letter = letter_code(req_tdata);
         item_in.last   = req_tlast;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// ----- rtl/rntd_accum.sv -----
// rntd_accum: held letter, running total and stop flag, one step per item,
// result register on the last character; depends on rntd_pkg
module rntd_accum #(
   parameter int TOTAL_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           plus_mode,
   input  logic                           item_valid,
   input  rntd_pkg::item_type             item,
   output logic                           item_take,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rntd_pkg::VALUE_WIDTH-1:0] rsp_tdata
);
   import rntd_pkg::*;

   localparam logic [TOTAL_WIDTH-1:0] TotalMax   = '1;
   localparam logic [TOTAL_WIDTH-1:0] NormalTop  = TOTAL_WIDTH'(NORMAL_MAX);

   letter_type               held_ff, held_in, held_step;
   logic [TOTAL_WIDTH-1:0]   total_ff, total_in, total_sat;
   logic [TOTAL_WIDTH:0]     total_sum;
   logic                     stopped_ff, stopped_in, stopped_step;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic [ADD_WIDTH-1:0]     add_step, add_last, pair;
   logic                     fire;

   // a last character waits only while an untaken result blocks the register
   assign item_take = item_valid && (!item.last || !rsp_valid_ff || rsp_tready);
   assign fire      = item_take;

   always_comb begin
      held_step    = held_ff;
      stopped_step = stopped_ff;
      add_step     = '0;
      pair         = pair_value(held_ff, item.letter);
      if (plus_mode || !stopped_ff) begin
         if (item.letter == LETTER_NONE) begin
            add_step  = letter_value(held_ff);
            held_step = LETTER_NONE;
            if (!plus_mode) begin
               stopped_step = 1'b1;
            end
         end else if (held_ff == LETTER_NONE) begin
            held_step = item.letter;
         end else if (pair != '0) begin
            add_step  = pair;
            held_step = LETTER_NONE;
         end else begin
            add_step  = letter_value(held_ff);
            held_step = item.letter;
         end
      end
      // on the last character the letter still held is flushed too
      add_last  = item.last ? letter_value(held_step) : '0;
      total_sum = {1'b0, total_ff} + (TOTAL_WIDTH+1)'(add_step)
                + (TOTAL_WIDTH+1)'(add_last);
      total_sat = total_sum[TOTAL_WIDTH] ? TotalMax : total_sum[TOTAL_WIDTH-1:0];
   end

   always_comb begin
      held_in      = held_ff;
      total_in     = total_ff;
      stopped_in   = stopped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         if (item.last) begin
            held_in      = LETTER_NONE;
            total_in     = '0;
            stopped_in   = 1'b0;
            rsp_valid_in = 1'b1;
            if (!plus_mode && (total_sat == '0 || total_sat > NormalTop)) begin
               rsp_data_in = '0;
            end else begin
               rsp_data_in = VALUE_WIDTH'(total_sat);
            end
         end else begin
            held_in    = held_step;
            total_in   = total_sat;
            stopped_in = stopped_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= LETTER_NONE;
         total_ff     <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         total_ff     <= total_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// ----- rtl/roman_numeral_token_decoder_top.sv -----
// roman_numeral_token_decoder_top: one character per transaction in, the decoded
// total out on the last character, through the character register and then the
// result register; throughput: one character every cycle, save that a last
// character waits while an untaken result holds the result register. synchronous
// active-high reset clears the held letter, total, stop flag, plus mode and both
// valids; depends on rntd_pkg, rntd_char_stage and rntd_accum
module roman_numeral_token_decoder_top #(
   parameter int TOTAL_WIDTH = 24     // accumulator width, saturating, 12 to 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // character stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_code
   input  logic                            req_tlast,   // last character of the token
   // decoded values
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rntd_pkg::VALUE_WIDTH-1:0] rsp_tdata,  // [23:0] value
   // configuration: plus mode
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data
);
   import rntd_pkg::*;

   logic     plus_mode_ff, plus_mode_in;
   logic     item_valid;
   item_type item;
   logic     item_take;

   // the register is to change only while idle, a rule on the user that the block does not enforce; it is always ready
   assign csr_ready    = 1'b1;
   assign plus_mode_in = (csr_valid && csr_ready) ? csr_data : plus_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_mode_ff <= 1'b0;
      end else begin
         plus_mode_ff <= plus_mode_in;
      end
   end

   // stage one: register the character and classify it as a letter code
   rntd_char_stage u_char_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // stage two: greedy pair matching, saturating add, result register
   rntd_accum #(
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .plus_mode  (plus_mode_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
